// ===== hw/rtl/ckb_pkg.sv =====
// Shared types, constants and functions for the keystream block generator.
// Used by every module under hw/rtl; depends on nothing else.
package ckb_pkg;

    localparam int WORD_W       = 32;
    localparam int CTR_W        = 64;
    localparam int PAIRS_W      = 6;
    localparam int ROUNDS_W     = 4;
    localparam int CFG_IDX_W    = 3;
    localparam int MAX_PAIRS    = 32;
    localparam int RESET_ROUNDS = 10;
    localparam int S_TDATA_W    = 72;
    localparam int M_TDATA_W    = 576;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_ROUNDS = 3'd5;

    // Constant row d, lane 3 in the high bits.
    localparam logic [127:0] CONST_ROW = 128'h6b206574_79622d32_00332064_6e617080;

    // Sixteen 32-bit state words, word 0 in the lowest bits.
    typedef logic [15:0][WORD_W-1:0] blk_t;

    typedef struct packed {
        logic [CTR_W-1:0]    key_word_0;
        logic [CTR_W-1:0]    key_word_1;
        logic [CTR_W-1:0]    key_word_2;
        logic [CTR_W-1:0]    key_word_3;
        logic [CTR_W-1:0]    nonce;
        logic [ROUNDS_W-1:0] double_rounds;
    } cfg_t;

    typedef struct packed {
        logic [CTR_W-1:0]   counter;
        logic [PAIRS_W-1:0] pairs;
    } job_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_EMIT0,
        ST_EMIT1
    } core_state_t;

    function automatic logic [WORD_W-1:0] rotl(logic [WORD_W-1:0] v, int unsigned s);
        return (v << s) | (v >> (WORD_W - s));
    endfunction

    function automatic blk_t init_block(cfg_t c, logic [CTR_W-1:0] ctr);
        return {CONST_ROW, ctr, c.nonce, c.key_word_3, c.key_word_2,
                c.key_word_1, c.key_word_0};
    endfunction

    // One half of a quarter round on all four lanes at once.
    // phase[1] selects diagonals, phase[0] selects the second half (rotates 8 and 7).
    function automatic blk_t round_step(blk_t x, logic [1:0] phase);
        blk_t y;
        logic [WORD_W-1:0] a, b, c, d;
        logic [1:0] la, lb, lc, ld;
        y = x;
        for (int k = 0; k < 4; k++) begin
            la = 2'(k);
            lb = phase[1] ? 2'(k + 1) : 2'(k);
            lc = phase[1] ? 2'(k + 2) : 2'(k);
            ld = phase[1] ? 2'(k + 3) : 2'(k);
            a = x[{2'd0, la}];
            b = x[{2'd1, lb}];
            c = x[{2'd2, lc}];
            d = x[{2'd3, ld}];
            if (!phase[0]) begin
                a = a + b; d = rotl(d ^ a, 16);
                c = c + d; b = rotl(b ^ c, 12);
            end else begin
                a = a + b; d = rotl(d ^ a, 8);
                c = c + d; b = rotl(b ^ c, 7);
            end
            y[{2'd0, la}] = a;
            y[{2'd1, lb}] = b;
            y[{2'd2, lc}] = c;
            y[{2'd3, ld}] = d;
        end
        return y;
    endfunction

    function automatic blk_t lane_add(blk_t x, blk_t i);
        blk_t y;
        for (int k = 0; k < 16; k++) begin
            y[k] = x[k] + i[k];
        end
        return y;
    endfunction

endpackage

// ===== hw/rtl/chacha_keystream_block_generator_unit.sv =====
// Top level of the keystream block generator: configuration registers, front
// end, job queue and block core. Depends on ckb_pkg, ckb_front, ckb_job_queue, ckb_core.
//
//   channel   direction  handshake             payload
//   cfg       in         cfg_valid/cfg_ready   cfg_index[2:0], cfg_data[63:0]
//   s_        in         s_tvalid/s_tready     s_tdata: start_counter, pair_count
//   m_        out        m_tvalid/m_tready     m_tdata: out_word_0..7, block_counter; m_tlast
//
// Each block pair runs R double rounds in the round loop (R = double_rounds, one half
// quarter round on all lanes of both blocks per cycle), then emits block 0 and block 1.
// Reset clears control state and sets double_rounds to 10; the key and nonce read as zero.
// The two-entry job queue takes requests until full while the core works or the output
// stalls; a stalled output holds the core after it has finished the next pair.
module chacha_keystream_block_generator_unit import ckb_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CTR_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // start_counter[63:0], pair_count[69:64], zero pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // out_word_0[63:0] .. out_word_7[511:448],
                                            // block_counter[575:512]
    output logic                 m_tlast    // last_block
);

    cfg_t cfg_reg, cfg_next;
    logic queue_full;
    logic push;
    job_t push_job;
    logic job_valid;
    job_t job;
    logic job_pop;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_KEY_WORD_0:    cfg_next.key_word_0    = cfg_data;
                REG_KEY_WORD_1:    cfg_next.key_word_1    = cfg_data;
                REG_KEY_WORD_2:    cfg_next.key_word_2    = cfg_data;
                REG_KEY_WORD_3:    cfg_next.key_word_3    = cfg_data;
                REG_NONCE:         cfg_next.nonce         = cfg_data;
                REG_DOUBLE_ROUNDS: cfg_next.double_rounds = cfg_data[ROUNDS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{key_word_0:    '0,
                         key_word_1:    '0,
                         key_word_2:    '0,
                         key_word_3:    '0,
                         nonce:         '0,
                         double_rounds: ROUNDS_W'(RESET_ROUNDS)};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ckb_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .queue_full (queue_full),
        .push       (push),
        .job        (push_job)
    );

    ckb_job_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .full      (queue_full),
        .job_valid (job_valid),
        .job       (job),
        .pop       (job_pop)
    );

    ckb_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== hw/rtl/ckb_front.sv =====
// Input side: takes request transactions, clamps the pair count and drops
// requests that ask for no pairs. Depends on ckb_pkg.
module ckb_front import ckb_pkg::*; (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // start_counter[63:0], pair_count[69:64]
    input  logic                 queue_full,
    output logic                 push,
    output job_t                 job
);

    logic [PAIRS_W-1:0] raw_pairs;

    assign raw_pairs   = s_tdata[CTR_W +: PAIRS_W];
    assign s_tready    = !queue_full;
    assign job.counter = s_tdata[CTR_W-1:0];
    assign job.pairs   = (raw_pairs > PAIRS_W'(MAX_PAIRS)) ? PAIRS_W'(MAX_PAIRS) : raw_pairs;
    assign push        = s_tvalid && !queue_full && (raw_pairs != '0);

endmodule

// ===== hw/rtl/ckb_job_queue.sv =====
// Two-entry job queue between the request front end and the block core.
// Depends on ckb_pkg.
module ckb_job_queue import ckb_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    output logic job_valid,
    output job_t job,
    input  logic pop
);

    job_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign job_valid = (count_reg != 2'd0);
    assign job       = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == 2'd2 |-> !push || pop)
        else $error("job queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != 2'd0)
        else $error("job queue read while empty");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("job queue count out of range");
`endif

endmodule

// ===== hw/rtl/ckb_core.sv =====
// Block core: runs the rounds on two block states in parallel, adds the input
// state back and drives the result register. Depends on ckb_pkg.
module ckb_core import ckb_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 job_valid,
    input  job_t                 job,
    output logic                 job_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    core_state_t          state_reg, state_next;
    blk_t                 blk0_reg, blk0_next;
    blk_t                 blk1_reg, blk1_next;
    logic [CTR_W-1:0]     ctr_reg, ctr_next;
    logic [PAIRS_W-1:0]   pairs_left_reg, pairs_left_next;
    logic [ROUNDS_W-1:0]  round_index_reg, round_index_next;
    logic [1:0]           phase_reg, phase_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tlast_reg, m_tlast_next;

    logic                 out_free;
    logic [CTR_W-1:0]     ctr_plus1, ctr_plus2, ctr_plus3;
    logic [ROUNDS_W-1:0]  last_round;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign ctr_plus1  = ctr_reg + CTR_W'(1);
    assign ctr_plus2  = ctr_reg + CTR_W'(2);
    assign ctr_plus3  = ctr_reg + CTR_W'(3);
    assign last_round = cfg.double_rounds - ROUNDS_W'(1);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        state_next       = state_reg;
        blk0_next        = blk0_reg;
        blk1_next        = blk1_reg;
        ctr_next         = ctr_reg;
        pairs_left_next  = pairs_left_reg;
        round_index_next = round_index_reg;
        phase_next       = phase_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tlast_next     = m_tlast_reg;
        job_pop          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    job_pop          = 1'b1;
                    ctr_next         = job.counter;
                    pairs_left_next  = job.pairs;
                    blk0_next        = init_block(cfg, job.counter);
                    blk1_next        = init_block(cfg, job.counter + CTR_W'(1));
                    round_index_next = '0;
                    phase_next       = 2'd0;
                    state_next       = (cfg.double_rounds == '0) ? ST_EMIT0 : ST_ROUND;
                end
            end
            ST_ROUND: begin
                blk0_next  = round_step(blk0_reg, phase_reg);
                blk1_next  = round_step(blk1_reg, phase_reg);
                phase_next = phase_reg + 2'd1;
                if (phase_reg == 2'd3) begin
                    round_index_next = round_index_reg + ROUNDS_W'(1);
                    if (round_index_reg == last_round) begin
                        round_index_next = '0;
                        state_next       = ST_EMIT0;
                    end
                end
            end
            ST_EMIT0: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {ctr_reg, lane_add(blk0_reg, init_block(cfg, ctr_reg))};
                    m_tlast_next  = 1'b0;
                    state_next    = ST_EMIT1;
                end
            end
            ST_EMIT1: begin
                if (out_free) begin
                    m_tvalid_next   = 1'b1;
                    m_tdata_next    = {ctr_plus1,
                                       lane_add(blk1_reg, init_block(cfg, ctr_plus1))};
                    m_tlast_next    = (pairs_left_reg == PAIRS_W'(1));
                    pairs_left_next = pairs_left_reg - PAIRS_W'(1);
                    ctr_next        = ctr_plus2;
                    if (pairs_left_reg == PAIRS_W'(1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        // Start the next pair while the result waits in the output register.
                        blk0_next  = init_block(cfg, ctr_plus2);
                        blk1_next  = init_block(cfg, ctr_plus3);
                        phase_next = 2'd0;
                        state_next = (cfg.double_rounds == '0) ? ST_EMIT0 : ST_ROUND;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            ctr_reg         <= '0;
            pairs_left_reg  <= '0;
            round_index_reg <= '0;
            phase_reg       <= 2'd0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            ctr_reg         <= ctr_next;
            pairs_left_reg  <= pairs_left_next;
            round_index_reg <= round_index_next;
            phase_reg       <= phase_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        blk0_reg    <= blk0_next;
        blk1_reg    <= blk1_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

`ifndef SYNTHESIS
    a_busy_has_pairs: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> pairs_left_reg != '0 && pairs_left_reg <= PAIRS_W'(MAX_PAIRS))
        else $error("core busy with an empty or oversized pair count");
    a_round_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ROUND |-> round_index_reg < cfg.double_rounds)
        else $error("round index past configured count");
    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT1 && out_free && pairs_left_reg == PAIRS_W'(1)
        |=> state_reg == ST_IDLE && m_tvalid_reg && m_tlast_reg)
        else $error("final block did not end the run");
    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        job_pop |-> state_reg == ST_IDLE && job_valid)
        else $error("job taken while core busy");
`endif

endmodule
